FILE: design/rbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared types and codes for the three-rotor byte cipher.
// ----------------------------------------------------------------------------
package rbc_pkg;

	localparam int S_TDATA_W   = 32;
	localparam int S_TUSER_W   = 4;
	localparam int M_TDATA_W   = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_SEEK  = 2'd1;
	localparam logic [1:0] OP_CRYPT = 2'd2;

	localparam logic [1:0] SEL_FIRST  = 2'd0;
	localparam logic [1:0] SEL_SECOND = 2'd1;
	localparam logic [1:0] SEL_THIRD  = 2'd2;
	localparam logic [1:0] SEL_NONE   = 2'd3;

	typedef enum logic {
		KIND_LOAD,
		KIND_CRYPT
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [1:0] sel;
		logic [7:0] addr;
		logic [7:0] data;
		logic [7:0] n1;
		logic [7:0] n2;
		logic       last;
	} cmd_t;

endpackage

FILE: design/rbc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_front
// Accepts input items, applies seeks, tags crypt items with rotor positions.
// ----------------------------------------------------------------------------
module rbc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rbc_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [rbc_pkg::S_TUSER_W-1:0]   s_tuser,
	input  logic                            s_tlast,
	input  logic                            q_full,
	output logic                            q_push,
	output rbc_pkg::cmd_t                   q_cmd
);

	logic [7:0] n1_q;
	logic [7:0] n2_q;
	logic [1:0] op;
	logic [1:0] sel;
	logic       accept;

	assign op       = s_tuser[1:0];
	assign sel      = s_tuser[3:2];
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		q_cmd.kind = (op == rbc_pkg::OP_CRYPT) ? rbc_pkg::KIND_CRYPT : rbc_pkg::KIND_LOAD;
		q_cmd.sel  = sel;
		q_cmd.addr = s_tdata[7:0];
		q_cmd.data = s_tdata[15:8];
		q_cmd.n1   = n1_q;
		q_cmd.n2   = n2_q;
		q_cmd.last = s_tlast;
		unique case (op)
			rbc_pkg::OP_LOAD:  q_push = accept && (sel != rbc_pkg::SEL_NONE);
			rbc_pkg::OP_CRYPT: q_push = accept;
			default:           q_push = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n1_q <= 8'd0;
			n2_q <= 8'd0;
		end else if (accept) begin
			unique case (op)
				rbc_pkg::OP_SEEK: begin
					n1_q <= s_tdata[23:16];
					n2_q <= s_tdata[31:24];
				end
				rbc_pkg::OP_CRYPT: begin
					n1_q <= n1_q + 8'd1;
					if (n1_q == 8'hff) begin
						n2_q <= n2_q + 8'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: design/rbc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_queue
// Short FIFO of tagged commands between the front and the back.
// ----------------------------------------------------------------------------
module rbc_queue #(
	parameter int DEPTH = rbc_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rbc_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output rbc_pkg::cmd_t head_cmd
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rbc_pkg::cmd_t    slot_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + IDX_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + IDX_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: design/rbc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbc_back
// Three-stage table lookup pipeline with output register.
// ----------------------------------------------------------------------------
module rbc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  rbc_pkg::cmd_t                 head_cmd,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rbc_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	logic [7:0] tab1_mem [256];
	logic [7:0] tab2_mem [256];
	logic [7:0] tab3_mem [256];

	logic          v_s1, v_s2, v_s3;
	rbc_pkg::cmd_t c_s1, c_s2, c_s3;
	logic [7:0]    rd_s1, rd_s2, rd_s3;
	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;
	logic          adv;
	logic [7:0]    addr1, addr2, addr3;
	logic          wr1, wr2, wr3;

	assign adv   = !out_valid_q || m_tready;
	assign pop   = adv && head_valid;
	assign addr1 = head_cmd.data + head_cmd.n1;
	assign addr2 = rd_s1 + c_s1.n2;
	assign addr3 = rd_s2 - c_s2.n2;
	assign wr1   = head_valid && (head_cmd.kind == rbc_pkg::KIND_LOAD)
		&& (head_cmd.sel == rbc_pkg::SEL_FIRST);
	assign wr3   = v_s1 && (c_s1.kind == rbc_pkg::KIND_LOAD) && (c_s1.sel == rbc_pkg::SEL_THIRD);
	assign wr2   = v_s2 && (c_s2.kind == rbc_pkg::KIND_LOAD) && (c_s2.sel == rbc_pkg::SEL_SECOND);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr1) begin
				tab1_mem[head_cmd.addr] <= head_cmd.data;
			end
			rd_s1 <= tab1_mem[addr1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr3) begin
				tab3_mem[c_s1.addr] <= c_s1.data;
			end
			rd_s2 <= tab3_mem[addr2];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (wr2) begin
				tab2_mem[c_s2.addr] <= c_s2.data;
			end
			rd_s3 <= tab2_mem[addr3];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_s1       <= head_cmd;
			c_s2       <= c_s1;
			c_s3       <= c_s2;
			out_data_q <= rd_s3 - c_s3.n1;
			out_last_q <= c_s3.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && (c_s3.kind == rbc_pkg::KIND_CRYPT);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: design/rotor_byte_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotor_byte_cipher_top
// Three-rotor byte stream cipher: table loads, seeks and byte transforms.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata, tuser, tlast: load, seek or crypt item
// m_*      out  m_tvalid/m_tready  tdata, tlast: one transformed byte per crypt
//
// One item per cycle, set by the queue pop and the three-stage lookup pipeline
// (one table memory read port per stage), except that a stalled output holds
// the pipeline. A crypt byte is registered in the queue, each lookup stage and
// the output. Reset clears rotors and control; the tables are undefined until
// loaded and need no clearing pass. s_tready drops only when the queue fills.
// ----------------------------------------------------------------------------
module rotor_byte_cipher_top #(
	parameter int QUEUE_DEPTH = rbc_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [7:0] entry_index, [15:8] data_value, [31:16] position
	input  logic [rbc_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] operation, [3:2] table_select
	input  logic [rbc_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [7:0] result_byte
	output logic [rbc_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                          m_tlast
);

	logic          q_full;
	logic          q_push;
	rbc_pkg::cmd_t q_cmd;
	logic          q_pop;
	logic          head_valid;
	rbc_pkg::cmd_t head_cmd;

	rbc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	rbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	rbc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule
